// ===== hw/rtl/vrc_pkg.sv =====
// ---------------------------------------------------------------------------
// vrc_pkg: shared constants and helpers
// Register indexes, fixed-point constants and the exponent table step ratio
// for the volume ray compositor.
// ---------------------------------------------------------------------------
`default_nettype none

package vrc_pkg;

  localparam int unsigned EXP_TABLE_ENTRIES_DEF = 1024;

  localparam logic [2:0] CFG_ABSORB_SCALE = 3'd0;
  localparam logic [2:0] CFG_INV_KAPA     = 3'd1;
  localparam logic [2:0] CFG_LIGHT_RED    = 3'd2;
  localparam logic [2:0] CFG_LIGHT_GREEN  = 3'd3;
  localparam logic [2:0] CFG_LIGHT_BLUE   = 3'd4;
  localparam logic [2:0] CFG_CUTOFF       = 3'd5;

  localparam logic [24:0] ONE24   = 25'h100_0000;
  localparam logic [23:0] ACC_MAX = 24'hFF_FFFF;
  localparam logic [12:0] COLOR_ONE = 13'd4096;
  localparam logic [16:0] TRANS_ONE = 17'd65536;

  // Per-entry ratio of the exponent table, series of exp(-y/2^32) in Q0.32.
  function automatic logic [63:0] exp_ratio(input logic [63:0] y);
    logic [63:0] term;
    logic [63:0] r;
    term = 64'h1_0000_0000;
    r    = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      if (k[0]) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    return r;
  endfunction

  function automatic logic [12:0] sat_color(input logic [12:0] v);
    return (v > COLOR_ONE) ? COLOR_ONE : v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/volume_ray_compositor.sv =====
// Volume ray compositor. Samples of a ray arrive front to back; one result
// (8-bit RGB) leaves on a last or short sample. After reset the block fills
// its exponent table, one entry a cycle, with in_stall_o high; configuration
// writes are taken throughout. All products go through one shared 32x32
// multiplier stepped by a sequencer: a sample with zero density or on a
// terminated ray goes from ST_IDLE to ST_FIN, a composited sample steps
// on from ST_XMUL, a last sample then through ST_BG/ST_PIX per channel
// and ST_DONE, a short ray only through those. A result waiting on
// out_stall_i does not block the next sample until that sample has its result.
// ---------------------------------------------------------------------------
// volume_ray_compositor: front-to-back emission/absorption compositing
// Iterative datapath around one shared multiplier and a table memory.
// ---------------------------------------------------------------------------
`default_nettype none

module volume_ray_compositor #(
  parameter int unsigned EXP_TABLE_ENTRIES = vrc_pkg::EXP_TABLE_ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [24:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        first_sample_i,
  input  wire logic        last_sample_i,
  input  wire logic        short_ray_i,
  input  wire logic [15:0] density_i,
  input  wire logic [12:0] voxel_red_i,
  input  wire logic [12:0] voxel_green_i,
  input  wire logic [12:0] voxel_blue_i,
  input  wire logic [16:0] light_trans_i,
  input  wire logic [12:0] bg_red_i,
  input  wire logic [12:0] bg_green_i,
  input  wire logic [12:0] bg_blue_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  pixel_red_o,
  output      logic [7:0]  pixel_green_o,
  output      logic [7:0]  pixel_blue_o
);

  localparam int unsigned AW = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int unsigned IW = AW + 4;
  localparam int unsigned PW = 28 + IW;
  localparam logic [63:0] ExpStep  = (64'd16 << 32) / EXP_TABLE_ENTRIES;
  localparam logic [63:0] ExpRatio = vrc_pkg::exp_ratio(ExpStep);
  localparam logic [AW-1:0] LastAddr = AW'(EXP_TABLE_ENTRIES);

  typedef enum logic [16:0] {
    ST_FILL  = 17'b0_0000_0000_0000_0001,
    ST_IDLE  = 17'b0_0000_0000_0000_0010,
    ST_XMUL  = 17'b0_0000_0000_0000_0100,
    ST_PMUL  = 17'b0_0000_0000_0000_1000,
    ST_RD0   = 17'b0_0000_0000_0001_0000,
    ST_RD1   = 17'b0_0000_0000_0010_0000,
    ST_RD2   = 17'b0_0000_0000_0100_0000,
    ST_TMUL  = 17'b0_0000_0000_1000_0000,
    ST_AMUL  = 17'b0_0000_0001_0000_0000,
    ST_WMUL1 = 17'b0_0000_0010_0000_0000,
    ST_WMUL2 = 17'b0_0000_0100_0000_0000,
    ST_CMUL  = 17'b0_0000_1000_0000_0000,
    ST_MAC   = 17'b0_0001_0000_0000_0000,
    ST_FIN   = 17'b0_0010_0000_0000_0000,
    ST_BG    = 17'b0_0100_0000_0000_0000,
    ST_PIX   = 17'b0_1000_0000_0000_0000,
    ST_DONE  = 17'b1_0000_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] absorb_q, kapa_q;
  logic [12:0] light_q [3];
  logic [24:0] cutoff_q;

  logic [24:0] trans_q, trans_d;
  logic [23:0] acc_q [3];
  logic [23:0] acc_d [3];
  logic        term_q, term_d;
  logic [1:0]  ch_q, ch_d;
  logic [AW-1:0] fill_q, fill_d;
  logic [32:0] v_q, v_d;
  logic        out_valid_q, out_valid_d;

  logic        last_q, last_d;
  logic [15:0] dens_q, dens_d;
  logic [12:0] vox_q [3];
  logic [12:0] vox_d [3];
  logic [12:0] bg_q [3];
  logic [12:0] bg_d [3];
  logic [16:0] qt_q, qt_d;
  logic [31:0] x_q, x_d;
  logic [PW-1:0] p_q, p_d;
  logic [24:0] t0_q, t0_d;
  logic [24:0] dt_q, dt_d;
  logic [27:0] w_q, w_d;
  logic [12:0] c_q, c_d;
  logic [25:0] s_q, s_d;
  logic [7:0]  pix_q [3];
  logic [7:0]  pix_d [3];
  logic [7:0]  pout_q [3];
  logic [7:0]  pout_d [3];

  logic [24:0] exp_mem [EXP_TABLE_ENTRIES + 1];
  logic [24:0] rdata_q;
  logic [AW-1:0] raddr;
  logic [24:0] fill_entry;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [IW-1:0] idx;
  logic        in_range;
  logic        accept;
  logic        eff_term;
  logic [28:0] mac_sum;
  logic [64:0] v_round;

  function automatic logic [12:0] vox_sat(input logic [12:0] v);
    return vrc_pkg::sat_color(v);
  endfunction

  assign mul_p      = mul_a * mul_b;
  assign idx        = p_q[PW-1:28];
  assign in_range   = idx < IW'(EXP_TABLE_ENTRIES);
  assign accept     = in_valid_i && !in_stall_o;
  assign eff_term   = first_sample_i ? 1'b0 : term_q;
  assign mac_sum    = 29'(acc_q[ch_q]) + mul_p[40:12];
  assign v_round    = 65'(mul_p) + 65'h0_8000_0000;
  assign fill_entry = 25'((34'(v_q) + 34'd128) >> 8);

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pixel_red_o   = pout_q[0];
  assign pixel_green_o = pout_q[1];
  assign pixel_blue_o  = pout_q[2];

  always_comb begin
    state_d     = state_q;
    trans_d     = trans_q;
    acc_d       = acc_q;
    term_d      = term_q;
    ch_d        = ch_q;
    fill_d      = fill_q;
    v_d         = v_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    dens_d      = dens_q;
    vox_d       = vox_q;
    bg_d        = bg_q;
    qt_d        = qt_q;
    x_d         = x_q;
    p_d         = p_q;
    t0_d        = t0_q;
    dt_d        = dt_q;
    w_d         = w_q;
    c_d         = c_q;
    s_d         = s_q;
    pix_d       = pix_q;
    pout_d      = pout_q;
    mul_a       = '0;
    mul_b       = '0;
    raddr       = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_FILL: begin
        mul_a  = v_q[31:0];
        mul_b  = ExpRatio[31:0];
        v_d    = (fill_q == '0) ? {1'b0, ExpRatio[31:0]} : v_round[64:32];
        fill_d = fill_q + AW'(1);
        if (fill_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          last_d = last_sample_i;
          dens_d = density_i;
          vox_d[0] = vox_sat(voxel_red_i);
          vox_d[1] = vox_sat(voxel_green_i);
          vox_d[2] = vox_sat(voxel_blue_i);
          bg_d[0]  = vox_sat(bg_red_i);
          bg_d[1]  = vox_sat(bg_green_i);
          bg_d[2]  = vox_sat(bg_blue_i);
          qt_d = (light_trans_i > vrc_pkg::TRANS_ONE) ? vrc_pkg::TRANS_ONE : light_trans_i;
          ch_d = '0;
          if (first_sample_i || short_ray_i) begin
            trans_d = vrc_pkg::ONE24;
            acc_d   = '{default: '0};
            term_d  = 1'b0;
          end
          if (short_ray_i) begin
            state_d = ST_BG;
          end else if (!eff_term && density_i != '0) begin
            state_d = ST_XMUL;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_XMUL: begin
        mul_a   = 32'(absorb_q);
        mul_b   = 32'(dens_q);
        x_d     = mul_p[31:0];
        state_d = ST_PMUL;
      end
      ST_PMUL: begin
        mul_a   = x_q;
        mul_b   = 32'(EXP_TABLE_ENTRIES);
        p_d     = mul_p[PW-1:0];
        state_d = ST_RD0;
      end
      ST_RD0: begin
        raddr   = in_range ? idx[AW-1:0] : '0;
        state_d = ST_RD1;
      end
      ST_RD1: begin
        raddr   = in_range ? idx[AW-1:0] + AW'(1) : '0;
        t0_d    = rdata_q;
        state_d = ST_RD2;
      end
      ST_RD2: begin
        mul_a   = 32'(t0_q - rdata_q);
        mul_b   = 32'(p_q[27:0]);
        dt_d    = in_range ? t0_q - mul_p[52:28] : '0;
        state_d = ST_TMUL;
      end
      ST_TMUL: begin
        mul_a   = 32'(trans_q);
        mul_b   = 32'(dt_q);
        trans_d = mul_p[48:24];
        state_d = ST_AMUL;
      end
      ST_AMUL: begin
        if (trans_q < cutoff_q) begin
          term_d  = 1'b1;
          state_d = ST_FIN;
        end else begin
          mul_a   = 32'(vrc_pkg::ONE24 - dt_q);
          mul_b   = 32'(kapa_q);
          w_d     = mul_p[39:12];
          state_d = ST_WMUL1;
        end
      end
      ST_WMUL1: begin
        mul_a   = 32'(w_q);
        mul_b   = 32'(trans_q);
        w_d     = mul_p[51:24];
        state_d = ST_WMUL2;
      end
      ST_WMUL2: begin
        mul_a   = 32'(w_q);
        mul_b   = 32'(qt_q);
        w_d     = mul_p[43:16];
        ch_d    = '0;
        state_d = ST_CMUL;
      end
      ST_CMUL: begin
        mul_a   = 32'(vox_q[ch_q]);
        mul_b   = 32'(vrc_pkg::sat_color(light_q[ch_q]));
        c_d     = mul_p[24:12];
        state_d = ST_MAC;
      end
      ST_MAC: begin
        mul_a = 32'(w_q);
        mul_b = 32'(c_q);
        acc_d[ch_q] = (mac_sum > 29'(vrc_pkg::ACC_MAX)) ? vrc_pkg::ACC_MAX : mac_sum[23:0];
        if (ch_q == 2'd2) begin
          state_d = ST_FIN;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_CMUL;
        end
      end
      ST_FIN: begin
        ch_d    = '0;
        state_d = last_q ? ST_BG : ST_IDLE;
      end
      ST_BG: begin
        mul_a   = 32'(bg_q[ch_q]);
        mul_b   = 32'(trans_q);
        s_d     = 26'(acc_q[ch_q]) + 26'(mul_p[36:12]);
        state_d = ST_PIX;
      end
      ST_PIX: begin
        mul_a = 32'(s_q);
        mul_b = 32'd255;
        pix_d[ch_q] = (s_q >= 26'(vrc_pkg::ACC_MAX)) ? 8'd255 : mul_p[31:24];
        if (ch_q == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_BG;
        end
      end
      ST_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          pout_d      = pix_q;
          out_valid_d = 1'b1;
          trans_d     = vrc_pkg::ONE24;
          acc_d       = '{default: '0};
          term_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      absorb_q    <= 16'd410;
      kapa_q      <= 16'd4096;
      light_q     <= '{default: 13'd4096};
      cutoff_q    <= 25'd17;
      trans_q     <= vrc_pkg::ONE24;
      acc_q       <= '{default: '0};
      term_q      <= 1'b0;
      ch_q        <= '0;
      fill_q      <= '0;
      v_q         <= 33'h1_0000_0000;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      trans_q     <= trans_d;
      acc_q       <= acc_d;
      term_q      <= term_d;
      ch_q        <= ch_d;
      fill_q      <= fill_d;
      v_q         <= v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          vrc_pkg::CFG_ABSORB_SCALE: absorb_q   <= cfg_data_i[15:0];
          vrc_pkg::CFG_INV_KAPA:     kapa_q     <= cfg_data_i[15:0];
          vrc_pkg::CFG_LIGHT_RED:    light_q[0] <= cfg_data_i[12:0];
          vrc_pkg::CFG_LIGHT_GREEN:  light_q[1] <= cfg_data_i[12:0];
          vrc_pkg::CFG_LIGHT_BLUE:   light_q[2] <= cfg_data_i[12:0];
          vrc_pkg::CFG_CUTOFF:       cutoff_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    dens_q <= dens_d;
    vox_q  <= vox_d;
    bg_q   <= bg_d;
    qt_q   <= qt_d;
    x_q    <= x_d;
    p_q    <= p_d;
    t0_q   <= t0_d;
    dt_q   <= dt_d;
    w_q    <= w_d;
    c_q    <= c_d;
    s_q    <= s_d;
    pix_q  <= pix_d;
    pout_q <= pout_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL) begin
      exp_mem[fill_q] <= fill_entry;
    end
    rdata_q <= exp_mem[raddr];
  end

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result appeared outside the done step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transfer taken without processing");

  a_trans_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trans_q <= vrc_pkg::ONE24)
    else $error("transmittance above one");

  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_q != 2'd3)
    else $error("channel counter out of range");

endmodule

`default_nettype wire
